@@ sv/easing_interpolator_macros.svh @@
// Assertion macros for the easing interpolator.
`ifndef EASING_INTERPOLATOR_MACROS_SVH
`define EASING_INTERPOLATOR_MACROS_SVH
`ifndef SYNTH
`define EI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define EI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define EI_ASSERT_IMP(label, clk, rst, ante, cons)
`define EI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/ei_pkg.sv @@
// ----------------------------------------------------------------------------
// ei_pkg
// Types and constants shared by the easing interpolator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package ei_pkg;
   localparam int QDEPTH = 4;
   localparam int QAW    = 2;
   localparam int QW     = 32;
   localparam int STAGES = 4;

   typedef enum logic [2:0] {
      CMD_LINEAR = 3'd0,
      CMD_IN2    = 3'd1,
      CMD_IN3    = 3'd2,
      CMD_IN4    = 3'd3,
      CMD_OUT2   = 3'd4,
      CMD_OUT3   = 3'd5,
      CMD_ZERO6  = 3'd6,
      CMD_ZERO7  = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      OP_DIRECT = 2'd0,   // result is base, num/den forced to 0/1
      OP_IN     = 2'd1,   // base + num/den
      OP_OUT    = 2'd2    // base - num/den
   } op_type;

   // classified request handed from the front to the back
   typedef struct packed {
      op_type      op;
      logic [31:0] base;
      logic [31:0] diff;
      logic [8:0]  t;      // signed: remaining steps go negative past the end
      logic [7:0]  n;
      logic [1:0]  extra;  // power minus one
   } item_type;
endpackage
`default_nettype wire

@@ sv/easing_interpolator.sv @@
// ----------------------------------------------------------------------------
// easing_interpolator
// Power-easing interpolation of a 16-bit range to a 32-bit value.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_* and raise start; a request is taken on each rising edge
//   with start high and busy low. busy rises only when the four-entry
//   queue between the front end and the compute pipeline is full, which
//   does not happen since the back end drains one request every cycle.
//   Each request yields exactly one rsp_valid pulse carrying rsp_value,
//   in request order, after the queue, four power stages, product
//   register, 33-stage restoring divider and output adder.
//   Throughput is one request per cycle, set by the fully pipelined
//   divider. The receiver cannot stall; results appear for one cycle.
//   Reset clears all valid bits and queue pointers; in-flight requests
//   are dropped.
// ----------------------------------------------------------------------------
`default_nettype none
`include "easing_interpolator_macros.svh"
module easing_interpolator import ei_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic [2:0]   req_cmd,
   input  wire logic [15:0]  req_start_value,
   input  wire logic [15:0]  req_end_value,
   input  wire logic [7:0]   req_step,
   input  wire logic [7:0]   req_step_count,
   output logic              rsp_valid,
   output logic [31:0]       rsp_value
);
   item_type head;
   logic     head_valid, pop, full;

   // front end: classify and queue requests
   ei_front u_front (
      .clock, .reset,
      .req_valid(start),
      .req_cmd, .req_start_value, .req_end_value, .req_step, .req_step_count,
      .pop, .head, .head_valid, .full
   );

   // back end: powers, product, divide, final add
   ei_back u_back (
      .clock, .reset, .head, .head_valid, .pop, .rsp_valid, .rsp_value
   );

   assign busy = full;

   `EI_ASSERT_IMP(a_busy_full, clock, reset, busy, head_valid)
endmodule
`default_nettype wire

@@ sv/ei_front.sv @@
// ----------------------------------------------------------------------------
// ei_front
// Accept requests, classify the curve and queue the work for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "easing_interpolator_macros.svh"
module ei_front import ei_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic [2:0]   req_cmd,
   input  wire logic [15:0]  req_start_value,
   input  wire logic [15:0]  req_end_value,
   input  wire logic [7:0]   req_step,
   input  wire logic [7:0]   req_step_count,
   input  wire logic         pop,
   output item_type          head,
   output logic              head_valid,
   output logic              full
);
   item_type            mem_ff [QDEPTH];
   logic [QAW:0]        wp_ff, wp_in, rp_ff, rp_in;
   item_type            it;
   logic [31:0]         from_w, to_w;
   logic                push;

   always_comb begin
      from_w = {{16{req_start_value[15]}}, req_start_value};
      to_w   = {{16{req_end_value[15]}}, req_end_value};
      it.base  = from_w;
      it.diff  = to_w - from_w;
      it.t     = {1'b0, req_step};
      it.n     = req_step_count;
      it.op    = OP_DIRECT;
      it.extra = 2'd0;
      if (req_step_count == 8'd0) begin
         it.base = to_w;
      end else begin
         case (cmd_type'(req_cmd))
            CMD_LINEAR: begin it.op = OP_IN; it.extra = 2'd0; end
            CMD_IN2:    begin it.op = OP_IN; it.extra = 2'd1; end
            CMD_IN3:    begin it.op = OP_IN; it.extra = 2'd2; end
            CMD_IN4:    begin it.op = OP_IN; it.extra = 2'd3; end
            CMD_OUT2: begin
               it.op = OP_OUT; it.extra = 2'd1; it.base = to_w;
               it.t = {1'b0, req_step_count} - {1'b0, req_step};
            end
            CMD_OUT3: begin
               it.op = OP_OUT; it.extra = 2'd2; it.base = to_w;
               it.t = {1'b0, req_step_count} - {1'b0, req_step};
            end
            default: it.base = 32'd0;
         endcase
      end
   end

   assign push       = req_valid && !full;
   assign full       = (wp_ff[QAW] != rp_ff[QAW]) && (wp_ff[QAW-1:0] == rp_ff[QAW-1:0]);
   assign head_valid = wp_ff != rp_ff;
   assign head       = mem_ff[rp_ff[QAW-1:0]];
   assign wp_in      = push ? wp_ff + 1'b1 : wp_ff;
   assign rp_in      = pop ? rp_ff + 1'b1 : rp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff[QAW-1:0]] <= it;
   end

   `EI_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, head_valid)
   `EI_ASSERT_NEXT(a_push_nonempty, clock, reset, push && !pop, head_valid)
   `EI_ASSERT_IMP(a_full_valid, clock, reset, full, head_valid)
endmodule
`default_nettype wire

@@ sv/ei_divider.sv @@
// ----------------------------------------------------------------------------
// ei_divider
// Pipelined signed 32-bit divider, truncating toward zero, one bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "easing_interpolator_macros.svh"
module ei_divider import ei_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire logic [31:0]  num,
   input  wire logic [31:0]  den,
   input  wire logic [31:0]  tag_base,
   input  wire logic         tag_sub,
   output logic              out_valid,
   output logic [31:0]       quo,
   output logic [31:0]       out_base,
   output logic              out_sub
);
   logic               v_ff   [QW+1];
   logic [31:0]        r_ff   [QW+1];
   logic [31:0]        q_ff   [QW+1];
   logic [31:0]        d_ff   [QW+1];
   logic [31:0]        b_ff   [QW+1];
   logic               s_ff   [QW+1];
   logic               neg_ff [QW+1];
   logic [31:0]        an, ad;

   assign an = num[31] ? 32'd0 - num : num;
   assign ad = den[31] ? 32'd0 - den : den;

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else       v_ff[0] <= in_valid;
      r_ff[0]   <= '0;
      q_ff[0]   <= an;
      d_ff[0]   <= ad;
      b_ff[0]   <= tag_base;
      s_ff[0]   <= tag_sub;
      neg_ff[0] <= num[31] ^ den[31];
   end

   for (genvar g = 0; g < QW; g++) begin : g_stage
      logic [32:0] sh, tr;
      assign sh = {r_ff[g], q_ff[g][31]};
      assign tr = sh - {1'b0, d_ff[g]};
      always_ff @(posedge clock) begin
         if (reset) v_ff[g+1] <= 1'b0;
         else       v_ff[g+1] <= v_ff[g];
         r_ff[g+1]   <= tr[32] ? sh[31:0] : tr[31:0];
         q_ff[g+1]   <= {q_ff[g][30:0], ~tr[32]};
         d_ff[g+1]   <= d_ff[g];
         b_ff[g+1]   <= b_ff[g];
         s_ff[g+1]   <= s_ff[g];
         neg_ff[g+1] <= neg_ff[g];
      end
   end

   assign out_valid = v_ff[QW];
   assign quo       = neg_ff[QW] ? 32'd0 - q_ff[QW] : q_ff[QW];
   assign out_base  = b_ff[QW];
   assign out_sub   = s_ff[QW];
endmodule
`default_nettype wire

@@ sv/ei_back.sv @@
// ----------------------------------------------------------------------------
// ei_back
// Compute powers and products, divide, and form the final value.
// ----------------------------------------------------------------------------
`default_nettype none
`include "easing_interpolator_macros.svh"
module ei_back import ei_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire item_type     head,
   input  wire logic         head_valid,
   output logic              pop,
   output logic              rsp_valid,
   output logic [31:0]       rsp_value
);
   // stage registers: each stage after the first multiplies in one more factor when extra calls for it
   logic [STAGES-1:0] v_ff;
   item_type          it_ff [STAGES];
   logic [31:0]       tp_ff [STAGES];
   logic [31:0]       np_ff [STAGES];
   logic [31:0]       num_ff, den_ff, base_ff;
   logic              dv_ff, sub_ff, direct_ff;
   logic              div_v, div_sub;
   logic [31:0]       div_q, div_base;
   logic              dir_v_ff;
   logic [31:0]       dir_val_ff;

   assign pop = head_valid;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= {v_ff[STAGES-2:0], pop};
      it_ff[0] <= head;
      tp_ff[0] <= {{23{head.t[8]}}, head.t};
      np_ff[0] <= {24'd0, head.n};
   end

   for (genvar g = 1; g < STAGES; g++) begin : g_pow
      always_ff @(posedge clock) begin
         it_ff[g] <= it_ff[g-1];
         if (it_ff[g-1].extra >= 2'(g)) begin
            tp_ff[g] <= tp_ff[g-1] * {{23{it_ff[g-1].t[8]}}, it_ff[g-1].t};
            np_ff[g] <= np_ff[g-1] * {24'd0, it_ff[g-1].n};
         end else begin
            tp_ff[g] <= tp_ff[g-1];
            np_ff[g] <= np_ff[g-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) dv_ff <= 1'b0;
      else       dv_ff <= v_ff[STAGES-1];
      num_ff    <= tp_ff[STAGES-1] * it_ff[STAGES-1].diff;
      den_ff    <= np_ff[STAGES-1];
      base_ff   <= it_ff[STAGES-1].base;
      sub_ff    <= it_ff[STAGES-1].op == OP_OUT;
      direct_ff <= it_ff[STAGES-1].op == OP_DIRECT;
   end

   ei_divider u_div (
      .clock, .reset,
      .in_valid (dv_ff),
      .num      (direct_ff ? 32'd0 : num_ff),
      .den      (direct_ff ? 32'd1 : den_ff),
      .tag_base (base_ff),
      .tag_sub  (sub_ff),
      .out_valid(div_v),
      .quo      (div_q),
      .out_base (div_base),
      .out_sub  (div_sub)
   );

   always_ff @(posedge clock) begin
      if (reset) dir_v_ff <= 1'b0;
      else       dir_v_ff <= div_v;
      dir_val_ff <= div_sub ? div_base - div_q : div_base + div_q;
   end

   assign rsp_valid = dir_v_ff;
   assign rsp_value = dir_val_ff;

   `EI_ASSERT_NEXT(a_div_out, clock, reset, div_v, rsp_valid)
   `EI_ASSERT_NEXT(a_stage_feed, clock, reset, v_ff[STAGES-1], dv_ff)
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the easing interpolator: a directed table of
// requests followed by random requests under varying sender idle rates,
// each response compared against an in-bench power-easing predictor.
// ----------------------------------------------------------------------------
module tb_top;
   import ei_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_cmd = '0;
   logic [15:0] req_start_value = '0;
   logic [15:0] req_end_value = '0;
   logic [7:0]  req_step = '0;
   logic [7:0]  req_step_count = '0;
   logic        rsp_valid;
   logic [31:0] rsp_value;

   // one directed request; exp_known marks rows whose value is typed in
   typedef struct {
      cmd_type     cmd;
      logic [15:0] from_v;
      logic [15:0] to_v;
      logic [7:0]  t;
      logic [7:0]  n;
      bit          exp_known;
      logic [31:0] exp_value;
   } curve_row_t;

   logic [31:0] value_queue[$];
   int          err_count = 0;
   int          idle_pct = 0;

   always #5 clock = ~clock;

   easing_interpolator dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_start_value (req_start_value),
      .req_end_value   (req_end_value),
      .req_step        (req_step),
      .req_step_count  (req_step_count),
      .rsp_valid       (rsp_valid),
      .rsp_value       (rsp_value)
   );

   // signed divide on wrapped patterns, truncating toward zero
   function automatic logic [31:0] div_trunc(logic [31:0] num, logic [31:0] den);
      logic [31:0] an;
      logic [31:0] ad;
      logic [31:0] q;
      an = num[31] ? -num : num;
      ad = den[31] ? -den : den;
      if (ad == 0) return '0;
      q = an / ad;
      return (num[31] ^ den[31]) ? -q : q;
   endfunction

   function automatic logic [31:0] power_of(logic [31:0] b, int p);
      logic [31:0] r;
      r = 32'd1;
      for (int i = 0; i < p; i++) r = r * b;
      return r;
   endfunction

   function automatic logic [31:0] eased_value(cmd_type cmd, logic [15:0] from_v,
                                               logic [15:0] to_v, logic [7:0] t,
                                               logic [7:0] n);
      logic [31:0] f;
      logic [31:0] e;
      logic [31:0] d;
      logic [31:0] rem;
      int          p;
      f = {{16{from_v[15]}}, from_v};
      e = {{16{to_v[15]}}, to_v};
      d = e - f;
      if (n == 0) return e;
      case (cmd)
         CMD_LINEAR, CMD_IN2, CMD_IN3, CMD_IN4: begin
            p = (cmd == CMD_LINEAR) ? 1 : int'(cmd) + 1;
            return f + div_trunc(power_of({24'd0, t}, p) * d, power_of({24'd0, n}, p));
         end
         CMD_OUT2, CMD_OUT3: begin
            p = int'(cmd) - 2;
            rem = {24'd0, n} - {24'd0, t};
            return f + d - div_trunc(power_of(rem, p) * d, power_of({24'd0, n}, p));
         end
         default: return '0;
      endcase
   endfunction

   // hold the request until taken, then predict its value
   task automatic send_request(cmd_type cmd, logic [15:0] from_v, logic [15:0] to_v,
                               logic [7:0] t, logic [7:0] n);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_cmd         <= cmd;
      req_start_value <= from_v;
      req_end_value   <= to_v;
      req_step        <= t;
      req_step_count  <= n;
      @(posedge clock);
      while (busy) @(posedge clock);
      value_queue.push_back(eased_value(cmd, from_v, to_v, t, n));
   endtask

   // check every response against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (value_queue.size() == 0) begin
            $display("%0t: unexpected response value=%h", $time, rsp_value);
            err_count++;
         end else begin
            logic [31:0] want;
            want = value_queue.pop_front();
            if (rsp_value !== want) begin
               $display("%0t: value mismatch expected=%h actual=%h", $time, want,
                        rsp_value);
               err_count++;
            end
         end
      end
   end

   initial begin
      curve_row_t rows[$];
      curve_row_t r;
      logic [31:0] got;
      int          waited;
      rows = '{
         // zero step count returns end value whatever the kind
         '{CMD_LINEAR, 16'h1234, 16'h8000, 8'd9, 8'd0, 1, 32'hFFFF8000},
         '{CMD_ZERO7, 16'h0000, 16'h7FFF, 8'd0, 8'd0, 1, 32'h00007FFF},
         '{CMD_OUT3, 16'hFFFF, 16'hFFFF, 8'hFF, 8'd0, 1, 32'hFFFFFFFF},
         // unused kinds give zero
         '{CMD_ZERO6, 16'h7FFF, 16'h8000, 8'd3, 8'd5, 1, 32'h0},
         '{CMD_ZERO7, 16'h8000, 16'h7FFF, 8'hFF, 8'hFF, 1, 32'h0},
         // ends of the curve and some points between
         '{CMD_LINEAR, 16'h8000, 16'h7FFF, 8'd0, 8'd215, 1, 32'hFFFF8000},
         '{CMD_LINEAR, 16'h8000, 16'h7FFF, 8'd215, 8'd215, 1, 32'h00007FFF},
         '{CMD_IN4, 16'h7FFF, 16'h8000, 8'd215, 8'd215, 0, '0},
         '{CMD_IN2, 16'h0000, 16'h0064, 8'd5, 8'd10, 1, 32'd25},
         '{CMD_IN3, 16'h8000, 16'h7FFF, 8'd100, 8'd200, 0, '0},
         '{CMD_OUT2, 16'h0000, 16'h0064, 8'd5, 8'd10, 1, 32'd75},
         '{CMD_OUT3, 16'h7FFF, 16'h8000, 8'd1, 8'd215, 0, '0},
         // step past step count, and step counts that overflow the power
         '{CMD_OUT2, 16'h0000, 16'h7FFF, 8'hFF, 8'd1, 0, '0},
         '{CMD_OUT3, 16'h8000, 16'h7FFF, 8'hFF, 8'd3, 0, '0},
         '{CMD_IN4, 16'h8000, 16'h7FFF, 8'hFF, 8'hFF, 0, '0},
         '{CMD_IN3, 16'h1234, 16'hABCD, 8'd250, 8'd255, 0, '0},
         '{CMD_IN2, 16'hFFFF, 16'h0001, 8'd7, 8'd1, 0, '0},
         '{CMD_LINEAR, 16'h5555, 16'hAAAA, 8'd170, 8'd85, 0, '0}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         r = rows[i];
         if (r.exp_known) begin
            got = eased_value(r.cmd, r.from_v, r.to_v, r.t, r.n);
            if (got !== r.exp_value) begin
               $display("%0t: table row %0d expected=%h actual=%h", $time, i,
                        r.exp_value, got);
               err_count++;
            end
         end
         send_request(r.cmd, r.from_v, r.to_v, r.t, r.n);
      end

      // random phases: no idling, mostly idle, then some idling
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 0 : (ph == 1) ? 59 : 30;
         for (int k = 0; k < 320; k++) begin
            logic [7:0] nn;
            logic [7:0] tt;
            nn = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(215));
            tt = ($urandom_range(5) == 0) ? 8'($urandom)
                 : 8'($urandom_range(nn));
            send_request(cmd_type'($urandom_range(7)), 16'($urandom), 16'($urandom),
                         tt, nn);
         end
         // hold start low for a stretch between phases
         start <= 1'b0;
         repeat ($urandom_range(20)) @(posedge clock);
      end
      start <= 1'b0;

      // drain outstanding predictions, then allow latency slack
      waited = 0;
      while (value_queue.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (60) @(posedge clock);
      if (err_count == 0 && value_queue.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #2ms;
      $display("FAIL");
      $finish;
   end
endmodule
